// ----- design/ufr_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the length-delimited UART frame receiver.
// Operation codes, register indexes and widths; no dependencies.
package ufr_pkg;

  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 9;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int TAIL_BYTES    = 4;
  localparam int DEF_BUF_DEPTH = 256;

  // Three physical byte buffers rotate through the assembly, slot A and slot B roles
  localparam int NUM_BUFS = 3;
  localparam int BID_W    = 2;

  localparam logic [BID_W-1:0] BID_ASM_RST = 2'd0;
  localparam logic [BID_W-1:0] BID_A_RST   = 2'd1;
  localparam logic [BID_W-1:0] BID_B_RST   = 2'd2;

  localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_WORD = 1'd1;

endpackage

// ----- design/uart_frame_receiver_double_buffer.sv -----
`timescale 1ns / 1ps
// An accepted item passes through s1 and then the output register before it shows on out_valid.
// Throughput: one item per cycle unless out_stall backs up; one access per cycle per single-port buffer.
// Reset (rst_n low, synchronous) clears roles, counters, slot flags and pipeline valids;
// the byte buffers are not cleared and need no clearing pass, since no read reaches
// a byte that the current frame did not write.
module uart_frame_receiver_double_buffer #(
  parameter int BUF_DEPTH = ufr_pkg::DEF_BUF_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ufr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ufr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ufr_pkg::OP_W-1:0]        in_op,
  input  logic [ufr_pkg::BYTE_W-1:0]      in_data,
  input  logic [ufr_pkg::BYTE_W-1:0]      in_index,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_frame_done,
  output logic                            out_frame_dropped,
  output logic                            out_overflow,
  output logic                            out_ready_res,
  output logic [ufr_pkg::LEN_W-1:0]       out_ready_len,
  output logic [ufr_pkg::BYTE_W-1:0]      out_read_data
);

  localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int LEN_W  = ufr_pkg::LEN_W;
  localparam int BYTE_W = ufr_pkg::BYTE_W;
  localparam int BID_W  = ufr_pkg::BID_W;
  localparam int TAIL_W = ufr_pkg::TAIL_BYTES * BYTE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] head_byte_r;
  logic [TAIL_W-1:0] tail_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= '0;
      tail_word_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ufr_pkg::CFG_HEAD_BYTE: head_byte_r <= cfg_data[BYTE_W-1:0];
        ufr_pkg::CFG_TAIL_WORD: tail_word_r <= cfg_data[TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: accept stage -> s1 (buffer read in flight) -> output register
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_acc;

  // s1 moves on whenever the output register is empty or being transferred
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and slot state
  // ---------------------------------------------------------------------------
  logic              receiving_r, receiving_nxt;
  logic [CNT_W-1:0]  fill_count_r, fill_count_nxt;
  logic [TAIL_W-1:0] last_four_r, last_four_nxt;
  logic [BYTE_W-1:0] length_field_r, length_field_nxt;
  logic [LEN_W-1:0]  slot_a_len_r, slot_a_len_nxt;
  logic [LEN_W-1:0]  slot_b_len_r, slot_b_len_nxt;
  logic              slot_a_full_r, slot_a_full_nxt;
  logic              slot_b_full_r, slot_b_full_nxt;
  logic [BID_W-1:0]  asm_id_r, asm_id_nxt;
  logic [BID_W-1:0]  a_id_r, a_id_nxt;
  logic [BID_W-1:0]  b_id_r, b_id_nxt;

  logic              is_rx, is_rd, is_rel;
  logic              rx_start, rx_ovf, rx_store, complete;
  logic [CNT_W-1:0]  fill_inc;
  logic [TAIL_W-1:0] last_four_sh;
  logic [BYTE_W-1:0] len_sel;
  logic              rd_hit;
  logic [BID_W-1:0]  srv_id;
  logic              res_done, res_dropped;

  // buffer access
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign is_rx  = (in_op == ufr_pkg::OP_RX_BYTE);
  assign is_rd  = (in_op == ufr_pkg::OP_READ);
  assign is_rel = (in_op == ufr_pkg::OP_RELEASE);

  assign fill_inc     = fill_count_r + CNT_W'(1);
  assign last_four_sh = {last_four_r[TAIL_W-BYTE_W-1:0], in_data};
  // the second byte of a frame is its length byte
  assign len_sel      = (fill_inc == CNT_W'(2)) ? in_data : length_field_r;

  assign rx_start = is_rx && !receiving_r && (in_data == head_byte_r);
  assign rx_ovf   = is_rx && receiving_r && (LEN_W'(fill_count_r) >= LEN_W'(BUF_DEPTH));
  assign rx_store = is_rx && receiving_r && !rx_ovf;
  assign complete = rx_store
                 && (LEN_W'(fill_inc) >= LEN_W'(ufr_pkg::TAIL_BYTES + 1))
                 && (last_four_sh == tail_word_r)
                 && ((LEN_W'(len_sel) + LEN_W'(ufr_pkg::TAIL_BYTES + 1)) == LEN_W'(fill_inc));

  // the served frame is slot A when full, else slot B
  assign srv_id = slot_a_full_r ? a_id_r : b_id_r;
  assign rd_hit = is_rd && (slot_a_full_r ? ({1'b0, in_index} < slot_a_len_r)
                                          : (slot_b_full_r && ({1'b0, in_index} < slot_b_len_r)));

  always_comb begin
    receiving_nxt    = receiving_r;
    fill_count_nxt   = fill_count_r;
    last_four_nxt    = last_four_r;
    length_field_nxt = length_field_r;
    slot_a_len_nxt   = slot_a_len_r;
    slot_b_len_nxt   = slot_b_len_r;
    slot_a_full_nxt  = slot_a_full_r;
    slot_b_full_nxt  = slot_b_full_r;
    asm_id_nxt       = asm_id_r;
    a_id_nxt         = a_id_r;
    b_id_nxt         = b_id_r;
    res_done         = 1'b0;
    res_dropped      = 1'b0;

    if (rx_start) begin
      receiving_nxt  = 1'b1;
      fill_count_nxt = CNT_W'(1);
      last_four_nxt  = TAIL_W'(in_data);
    end else if (rx_ovf) begin
      // drop the oversized frame; this byte does not open a new one
      receiving_nxt  = 1'b0;
      fill_count_nxt = '0;
    end else if (rx_store) begin
      fill_count_nxt   = fill_inc;
      last_four_nxt    = last_four_sh;
      length_field_nxt = len_sel;
      if (complete) begin
        res_done       = 1'b1;
        receiving_nxt  = 1'b0;
        fill_count_nxt = '0;
        // hand the assembly buffer to the free slot and take its old buffer back
        if (!slot_a_full_r) begin
          a_id_nxt        = asm_id_r;
          asm_id_nxt      = a_id_r;
          slot_a_len_nxt  = LEN_W'(fill_inc);
          slot_a_full_nxt = 1'b1;
        end else if (!slot_b_full_r) begin
          b_id_nxt        = asm_id_r;
          asm_id_nxt      = b_id_r;
          slot_b_len_nxt  = LEN_W'(fill_inc);
          slot_b_full_nxt = 1'b1;
        end else begin
          res_dropped = 1'b1;
        end
      end
    end else if (is_rel) begin
      if (slot_a_full_r) begin
        slot_a_full_nxt = 1'b0;
        slot_a_len_nxt  = '0;
      end else if (slot_b_full_r) begin
        slot_b_full_nxt = 1'b0;
        slot_b_len_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      receiving_r    <= 1'b0;
      fill_count_r   <= '0;
      last_four_r    <= '0;
      length_field_r <= '0;
      slot_a_len_r   <= '0;
      slot_b_len_r   <= '0;
      slot_a_full_r  <= 1'b0;
      slot_b_full_r  <= 1'b0;
      asm_id_r       <= ufr_pkg::BID_ASM_RST;
      a_id_r         <= ufr_pkg::BID_A_RST;
      b_id_r         <= ufr_pkg::BID_B_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // advance state only on an accepted transfer
      if (in_acc) begin
        receiving_r    <= receiving_nxt;
        fill_count_r   <= fill_count_nxt;
        last_four_r    <= last_four_nxt;
        length_field_r <= length_field_nxt;
        slot_a_len_r   <= slot_a_len_nxt;
        slot_b_len_r   <= slot_b_len_nxt;
        slot_a_full_r  <= slot_a_full_nxt;
        slot_b_full_r  <= slot_b_full_nxt;
        asm_id_r       <= asm_id_nxt;
        a_id_r         <= a_id_nxt;
        b_id_r         <= b_id_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte buffers: at most one write (assembly role) or one read (served role) per cycle.
  // Reader and writer always sit on different buffers, and a read in the cycle
  // after a role swap sees the write of the edge before, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  assign wr_en   = in_acc && (rx_start || rx_store);
  assign wr_addr = rx_start ? '0 : fill_count_r[ADDR_W-1:0];
  assign rd_en   = in_acc && is_rd;
  assign rd_addr = ADDR_W'(in_index);

  logic [BYTE_W-1:0] buf_q_r [ufr_pkg::NUM_BUFS];

  for (genvar g = 0; g < ufr_pkg::NUM_BUFS; g++) begin : g_buf
    logic [BYTE_W-1:0] mem [BUF_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (asm_id_r == BID_W'(g))) begin
        mem[wr_addr] <= in_data;
      end
      if (rd_en) begin
        buf_q_r[g] <= mem[rd_addr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s1 payload: flags and ready fields, plus the read select for the buffer output
  // ---------------------------------------------------------------------------
  logic             s1_done_r, s1_dropped_r, s1_ovf_r, s1_ready_res_r;
  logic [LEN_W-1:0] s1_ready_len_r;
  logic             s1_rd_hit_r;
  logic [BID_W-1:0] s1_rd_sel_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_done_r      <= res_done;
      s1_dropped_r   <= res_dropped;
      s1_ovf_r       <= rx_ovf;
      s1_ready_res_r <= slot_a_full_nxt || slot_b_full_nxt;
      s1_ready_len_r <= slot_a_full_nxt ? slot_a_len_nxt
                      : (slot_b_full_nxt ? slot_b_len_nxt : '0);
      s1_rd_hit_r    <= rd_hit;
      s1_rd_sel_r    <= srv_id;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic             out_done_r, out_dropped_r, out_ovf_r, out_ready_res_r;
  logic [LEN_W-1:0] out_ready_len_r;
  logic [BYTE_W-1:0] out_read_data_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_done_r      <= s1_done_r;
      out_dropped_r   <= s1_dropped_r;
      out_ovf_r       <= s1_ovf_r;
      out_ready_res_r <= s1_ready_res_r;
      out_ready_len_r <= s1_ready_len_r;
      out_read_data_r <= s1_rd_hit_r ? buf_q_r[s1_rd_sel_r] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_done    = out_done_r;
  assign out_frame_dropped = out_dropped_r;
  assign out_overflow      = out_ovf_r;
  assign out_ready_res     = out_ready_res_r;
  assign out_ready_len     = out_ready_len_r;
  assign out_read_data     = out_read_data_r;

endmodule

// ----- design/ufr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the frame receiver, bound to its top level.
// Depends on ufr_pkg for field widths.
module ufr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_frame_done,
  input logic                        out_frame_dropped,
  input logic                        out_overflow,
  input logic                        out_ready_res,
  input logic [ufr_pkg::LEN_W-1:0]   out_ready_len,
  input logic [ufr_pkg::BYTE_W-1:0]  out_read_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ready_len)
      && $stable(out_read_data) && $stable(out_frame_done))
    else $error("result changed while stalled");

  a_drop_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_dropped |-> out_frame_done)
    else $error("dropped frame without completion");

  a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ready_res == (out_ready_len != '0)))
    else $error("ready flag disagrees with served length");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_frame_done && out_read_data == '0)
    else $error("overflow reported with completion or read data");

endmodule

bind uart_frame_receiver_double_buffer ufr_checker u_ufr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_done    (out_frame_done),
  .out_frame_dropped (out_frame_dropped),
  .out_overflow      (out_overflow),
  .out_ready_res     (out_ready_res),
  .out_ready_len     (out_ready_len),
  .out_read_data     (out_read_data)
);
